[rtl/ubxr_pkg.sv]
// Shared types and constants for the UBX frame receiver.
`timescale 1ns / 1ps
`default_nettype none

package ubxr_pkg;

  // Sync bytes that open every frame
  localparam logic [7:0] SYNC_ONE = 8'hB5;
  localparam logic [7:0] SYNC_TWO = 8'h62;

  // Status codes of a frame report
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_BADCK   = 3'd1;
  localparam logic [2:0] ST_BADSYNC = 3'd2;
  localparam logic [2:0] ST_TOOLONG = 3'd3;
  localparam logic [2:0] ST_TIMEOUT = 3'd4;

  // Result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_REPORT  = 1'b1;

  // Input kinds
  localparam logic IN_BYTE = 1'b0;
  localparam logic IN_TICK = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 1'd1;

  // Reset values of the configuration registers
  localparam logic [15:0] MAX_PAYLOAD_RST   = 16'd1024;
  localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd1000;

  // One result item
  typedef struct packed {
    logic        kind;
    logic [2:0]  status;
    logic [7:0]  msg_class;
    logic [7:0]  msg_id;
    logic [15:0] frame_len;
    logic [15:0] byte_offset;
    logic [7:0]  data_byte;
  } res_t;

endpackage

`default_nettype wire

[rtl/ubxr_core.sv]
// Frame parser state, Fletcher checksum and timeout logic; one item per step.
`timescale 1ns / 1ps
`default_nettype none

module ubxr_core
  import ubxr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]          cfg_data,
  input  wire logic                 step,
  input  wire logic                 item_kind,
  input  wire logic [7:0]           item_byte,
  output logic                      res_valid,
  output res_t                      res
);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_PAYLOAD,
    PH_CKA,
    PH_CKB
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [2:0]  hdr_idx_r, hdr_idx_nxt;
  logic [7:0]  sync_first_r, sync_first_nxt;
  logic [7:0]  sync_second_r, sync_second_nxt;
  logic [7:0]  class_r, class_nxt;
  logic [7:0]  id_r, id_nxt;
  logic [15:0] length_r, length_nxt;
  logic [15:0] count_r, count_nxt;
  logic [7:0]  sum_a_r, sum_a_nxt;
  logic [7:0]  sum_b_r, sum_b_nxt;
  logic [7:0]  ck_a_r, ck_a_nxt;
  logic [15:0] wait_r, wait_nxt;
  logic [15:0] max_payload_r;
  logic [15:0] timeout_ticks_r;

  logic [7:0]  fl_a, fl_b;
  logic [15:0] wait_inc;
  logic [15:0] count_inc;
  logic [15:0] hdr_len;
  logic        rpt;
  logic [2:0]  rpt_status;
  logic        pay;

  // Fletcher step over the current byte
  assign fl_a      = sum_a_r + item_byte;
  assign fl_b      = sum_b_r + fl_a;
  assign wait_inc  = (wait_r == 16'hFFFF) ? wait_r : wait_r + 16'd1;
  assign count_inc = count_r + 16'd1;
  assign hdr_len   = {item_byte, length_r[7:0]};

  // Next-state logic
  always_comb begin
    phase_nxt       = phase_r;
    hdr_idx_nxt     = hdr_idx_r;
    sync_first_nxt  = sync_first_r;
    sync_second_nxt = sync_second_r;
    class_nxt       = class_r;
    id_nxt          = id_r;
    length_nxt      = length_r;
    count_nxt       = count_r;
    sum_a_nxt       = sum_a_r;
    sum_b_nxt       = sum_b_r;
    ck_a_nxt        = ck_a_r;
    wait_nxt        = wait_r;
    rpt             = 1'b0;
    rpt_status      = ST_OK;
    pay             = 1'b0;
    if (item_kind == IN_TICK) begin
      // ticks only count in the timed phases
      if (phase_r != PH_HEADER) begin
        wait_nxt = wait_inc;
        if (wait_inc >= timeout_ticks_r) begin
          rpt        = 1'b1;
          rpt_status = ST_TIMEOUT;
        end
      end
    end else begin
      case (phase_r)
        PH_HEADER: begin
          case (hdr_idx_r)
            3'd0: begin
              sync_first_nxt = item_byte;
              sum_a_nxt      = 8'd0;
              sum_b_nxt      = 8'd0;
              hdr_idx_nxt    = 3'd1;
            end
            3'd1: begin
              sync_second_nxt = item_byte;
              hdr_idx_nxt     = 3'd2;
            end
            3'd2: begin
              class_nxt   = item_byte;
              sum_a_nxt   = fl_a;
              sum_b_nxt   = fl_b;
              hdr_idx_nxt = 3'd3;
            end
            3'd3: begin
              id_nxt      = item_byte;
              sum_a_nxt   = fl_a;
              sum_b_nxt   = fl_b;
              hdr_idx_nxt = 3'd4;
            end
            3'd4: begin
              length_nxt  = {8'd0, item_byte};
              sum_a_nxt   = fl_a;
              sum_b_nxt   = fl_b;
              hdr_idx_nxt = 3'd5;
            end
            default: begin
              // last header byte: high length byte, then header checks
              length_nxt = hdr_len;
              sum_a_nxt  = fl_a;
              sum_b_nxt  = fl_b;
              if (sync_first_r != SYNC_ONE || sync_second_r != SYNC_TWO) begin
                rpt        = 1'b1;
                rpt_status = ST_BADSYNC;
              end else if (hdr_len > max_payload_r) begin
                rpt        = 1'b1;
                rpt_status = ST_TOOLONG;
              end else begin
                count_nxt   = 16'd0;
                wait_nxt    = 16'd0;
                hdr_idx_nxt = 3'd0;
                phase_nxt   = (hdr_len == 16'd0) ? PH_CKA : PH_PAYLOAD;
              end
            end
          endcase
        end
        PH_PAYLOAD: begin
          pay       = 1'b1;
          sum_a_nxt = fl_a;
          sum_b_nxt = fl_b;
          count_nxt = count_inc;
          if (count_inc >= length_r) begin
            phase_nxt = PH_CKA;
            wait_nxt  = 16'd0;
          end
        end
        PH_CKA: begin
          ck_a_nxt  = item_byte;
          phase_nxt = PH_CKB;
        end
        default: begin
          rpt        = 1'b1;
          rpt_status = (ck_a_r == sum_a_r && item_byte == sum_b_r) ? ST_OK : ST_BADCK;
        end
      endcase
    end
    // a report always restarts header collection
    if (rpt) begin
      phase_nxt   = PH_HEADER;
      hdr_idx_nxt = 3'd0;
      count_nxt   = 16'd0;
      wait_nxt    = 16'd0;
    end
  end

  // Result of this step
  always_comb begin
    res_valid       = rpt || pay;
    res.kind        = rpt ? KIND_REPORT : KIND_PAYLOAD;
    res.status      = rpt ? rpt_status : ST_OK;
    res.msg_class   = class_nxt;
    res.msg_id      = id_nxt;
    res.frame_len   = length_nxt;
    res.byte_offset = pay ? count_r : 16'd0;
    res.data_byte   = pay ? item_byte : 8'd0;
  end

  // State and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_HEADER;
      hdr_idx_r       <= 3'd0;
      sync_first_r    <= 8'd0;
      sync_second_r   <= 8'd0;
      class_r         <= 8'd0;
      id_r            <= 8'd0;
      length_r        <= 16'd0;
      count_r         <= 16'd0;
      sum_a_r         <= 8'd0;
      sum_b_r         <= 8'd0;
      ck_a_r          <= 8'd0;
      wait_r          <= 16'd0;
      max_payload_r   <= MAX_PAYLOAD_RST;
      timeout_ticks_r <= TIMEOUT_TICKS_RST;
    end else begin
      if (step) begin
        phase_r       <= phase_nxt;
        hdr_idx_r     <= hdr_idx_nxt;
        sync_first_r  <= sync_first_nxt;
        sync_second_r <= sync_second_nxt;
        class_r       <= class_nxt;
        id_r          <= id_nxt;
        length_r      <= length_nxt;
        count_r       <= count_nxt;
        sum_a_r       <= sum_a_nxt;
        sum_b_r       <= sum_b_nxt;
        ck_a_r        <= ck_a_nxt;
        wait_r        <= wait_nxt;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_MAX_PAYLOAD:   max_payload_r   <= cfg_data;
          CFG_TIMEOUT_TICKS: timeout_ticks_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

[rtl/ubxr_out_buf.sv]
// Two-entry result buffer that decouples the parser from the output stall.
`timescale 1ns / 1ps
`default_nettype none

module ubxr_out_buf
  import ubxr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  res_t      push_data,
  output logic      full,
  output logic      pop_valid,
  input  wire logic pop_ready,
  output res_t      pop_data
);

  res_t       slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       pop;

  assign full      = (count_r == 2'd2);
  assign pop_valid = (count_r != 2'd0);
  assign pop       = pop_valid && pop_ready;
  assign pop_data  = slot_r[rd_ptr_r];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/ubx_frame_receiver.sv]
// UBX frame receiver top level: input register, parser core, result buffer.
//
//  channel | dir | transfer when          | payload
//  in_     | in  | in_tvalid & in_tready   | tdata: rx_byte; tuser: kind
//  out_    | out | out_tvalid & out_tready | tdata: report/payload fields; tuser: out_kind
//  cfg_    | in  | cfg_we                  | cfg_index, cfg_data
//
// One item per cycle sustained while the result buffer is not full: an item is parsed
// while it sits in the input register; its result is written into the result buffer, which presents it on out_tvalid.
// Reset (synchronous, rst_n low) returns to header collection, loads register
// defaults and empties the result buffer; no clearing pass.
// The two-entry result buffer absorbs output stalls; input stalls only when it
// is full and an item is waiting in the input register.
`timescale 1ns / 1ps
`default_nettype none

module ubx_frame_receiver
  import ubxr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [7:0]           in_tdata,   // [7:0] rx_byte
  input  wire logic                 in_tuser,   // [0] kind
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [63:0]               out_tdata,  // [2:0] status, [10:3] msg_class,
                                                // [18:11] msg_id, [34:19] frame_len,
                                                // [50:35] byte_offset, [58:51] data_byte
  output logic                      out_tuser,  // [0] out_kind
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]          cfg_data
);

  logic       in_valid_r;
  logic       in_kind_r;
  logic [7:0] in_byte_r;
  logic       in_xfer;
  logic       step;
  logic       buf_full;
  logic       res_valid;
  res_t       res;
  res_t       out_res;

  assign step      = in_valid_r && !buf_full;
  assign in_tready = !in_valid_r || !buf_full;
  assign in_xfer   = in_tvalid && in_tready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_xfer) begin
      in_valid_r <= 1'b1;
    end else if (step) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_kind_r <= in_tuser;
      in_byte_r <= in_tdata;
    end
  end

  ubxr_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (step),
    .item_kind (in_kind_r),
    .item_byte (in_byte_r),
    .res_valid (res_valid),
    .res       (res)
  );

  ubxr_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (step && res_valid),
    .push_data (res),
    .full      (buf_full),
    .pop_valid (out_tvalid),
    .pop_ready (out_tready),
    .pop_data  (out_res)
  );

  // Output packing
  assign out_tuser = out_res.kind;
  assign out_tdata = {5'd0, out_res.data_byte, out_res.byte_offset,
                      out_res.frame_len, out_res.msg_id, out_res.msg_class,
                      out_res.status};

  // Input stalls only on a waiting item facing a full buffer
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (in_valid_r && buf_full))
    else $error("input stalled without a full result buffer");

  // Nothing is presented right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // Payload byte results always carry the ok status
  a_payload_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == KIND_PAYLOAD) |-> (out_tdata[2:0] == ST_OK))
    else $error("payload byte with nonzero status");

  // A full buffer never gets another push
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    buf_full |-> !(step && res_valid))
    else $error("push into full result buffer");

endmodule

`default_nettype wire
